/* sv/cts_pkg.sv */
package cts_pkg;

   localparam int ANGLE_W = 17;
   localparam int OUT_W   = 24;
   localparam int LIMIT_W = 5;
   localparam int POW_W   = 6;

   localparam int PROD_W  = 27;
   localparam int NUM_W   = 44;
   localparam int X_W     = 42;
   localparam int X_HALF  = 21;
   localparam int X2_W    = 28;
   localparam int T_W     = 43;
   localparam int T_LO    = 22;
   localparam int SUM_W   = 50;

   localparam logic [10:0]        ANGLE_SCALE = 11'd1571;
   localparam int                 X_DIVISOR   = 5625;
   localparam logic [16:0]        X_BIAS      = 17'd2812;
   localparam logic [63:0]        SQ_ROUND    = 64'h0000_0008_0000_0000;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd5;
   localparam logic [T_W-1:0]     TERM_ONE    = 43'h100000;

   localparam logic signed [SUM_W-1:0] ROUND_Q16  = 50'sd8;
   localparam logic signed [SUM_W-1:0] WRAP_FLOOR = -50'sd1099511627784;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

   typedef struct packed {
      logic [X2_W-1:0]         x2;
      logic [T_W-1:0]          t;
      logic signed [SUM_W-1:0] sum;
   } term_bus_type;

endpackage

/* sv/cts_cdiv.sv */
module cts_cdiv #(
   parameter int NW  = 44,
   parameter int DIV = 3
) (
   input  logic          clock,
   input  logic [1:0]    en,
   input  logic [NW-1:0] n_in,
   output logic [NW-1:0] q_out
);

   localparam int LW = $clog2(DIV);
   localparam int S  = NW + LW;
   localparam int MW = NW + 1;
   localparam int PW = NW + MW;
   localparam int NL = NW / 2;
   localparam int NH = NW - NL;
   localparam int ML = MW - MW / 2;
   localparam int MH = MW / 2;
   localparam logic [63:0] RECIP = ((64'd1 << S) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam logic [ML-1:0] M_LO = RECIP[ML-1:0];
   localparam logic [MH-1:0] M_HI = RECIP[MW-1:ML];

   logic [NL+ML-1:0] pll_in, pll_ff;
   logic [NL+MH-1:0] plh_in, plh_ff;
   logic [NH+ML-1:0] phl_in, phl_ff;
   logic [NH+MH-1:0] phh_in, phh_ff;
   logic [PW-1:0]    prod;
   logic [NW-1:0]    q_in, q_ff;

   // floor(n / DIV) as high part of n * ceil(2^S / DIV), exact for n < 2^NW
   always_comb begin
      pll_in = {{ML{1'b0}}, n_in[NL-1:0]} * {{NL{1'b0}}, M_LO};
      plh_in = {{MH{1'b0}}, n_in[NL-1:0]} * {{NL{1'b0}}, M_HI};
      phl_in = {{ML{1'b0}}, n_in[NW-1:NL]} * {{NH{1'b0}}, M_LO};
      phh_in = {{MH{1'b0}}, n_in[NW-1:NL]} * {{NH{1'b0}}, M_HI};
      prod   = PW'(pll_ff) + (PW'(plh_ff) << ML) + (PW'(phl_ff) << NL)
             + (PW'(phh_ff) << (NL + ML));
      q_in   = NW'(prod >> S);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phl_ff <= phl_in;
         phh_ff <= phh_in;
      end
      if (en[1]) begin
         q_ff <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

/* sv/cts_front.sv */
module cts_front (
   input  logic                               clock,
   input  logic [4:0]                         en,
   input  logic signed [cts_pkg::ANGLE_W-1:0] angle_deg,
   output logic [cts_pkg::X2_W-1:0]           x2
);

   logic [cts_pkg::ANGLE_W-1:0] mag;
   logic [cts_pkg::PROD_W-1:0]  prod_in, prod_ff;
   logic [cts_pkg::NUM_W-1:0]   q;
   logic [cts_pkg::X_W-1:0]     x;
   logic [2*cts_pkg::X_HALF-1:0] pll_in, pll_ff, plh_in, plh_ff, phh_in, phh_ff;
   logic [63:0]                 sq;
   logic [cts_pkg::X2_W-1:0]    x2_in, x2_ff;

   // degrees/128 to radians Q4.28: x = (|a| * 1571 * 2^17 + 2812) / 5625
   always_comb begin
      mag     = angle_deg[cts_pkg::ANGLE_W-1] ? cts_pkg::ANGLE_W'(-angle_deg)
                                               : cts_pkg::ANGLE_W'(angle_deg);
      prod_in = cts_pkg::PROD_W'({10'd0, mag} * {16'd0, cts_pkg::ANGLE_SCALE});
      x       = q[cts_pkg::X_W-1:0];
      pll_in  = {{cts_pkg::X_HALF{1'b0}}, x[cts_pkg::X_HALF-1:0]}
              * {{cts_pkg::X_HALF{1'b0}}, x[cts_pkg::X_HALF-1:0]};
      plh_in  = {{cts_pkg::X_HALF{1'b0}}, x[cts_pkg::X_HALF-1:0]}
              * {{cts_pkg::X_HALF{1'b0}}, x[cts_pkg::X_W-1:cts_pkg::X_HALF]};
      phh_in  = {{cts_pkg::X_HALF{1'b0}}, x[cts_pkg::X_W-1:cts_pkg::X_HALF]}
              * {{cts_pkg::X_HALF{1'b0}}, x[cts_pkg::X_W-1:cts_pkg::X_HALF]};
      // low 64 bits of x*x plus SQ_ROUND for rounding, wrapping
      sq      = 64'(pll_ff) + 64'({plh_ff, 22'd0}) + 64'({phh_ff, 42'd0})
              + cts_pkg::SQ_ROUND;
      x2_in   = sq[63:36];
   end

   cts_cdiv #(
      .NW  (cts_pkg::NUM_W),
      .DIV (cts_pkg::X_DIVISOR)
   ) u_xdiv (
      .clock (clock),
      .en    (en[2:1]),
      .n_in  ({prod_ff, cts_pkg::X_BIAS}),
      .q_out (q)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
      end
      if (en[3]) begin
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phh_ff <= phh_in;
      end
      if (en[4]) begin
         x2_ff <= x2_in;
      end
   end

   assign x2 = x2_ff;

endmodule

/* sv/cts_term.sv */
module cts_term #(
   parameter int POWER = 2
) (
   input  logic                         clock,
   input  logic [3:0]                   en,
   input  logic [cts_pkg::LIMIT_W-1:0]  term_limit,
   input  cts_pkg::term_bus_type        bus_in,
   output cts_pkg::term_bus_type        bus_out
);

   localparam int K      = POWER * (POWER - 1);
   localparam int P_PREV = POWER - 2;
   localparam bit ADD    = ((P_PREV / 2) % 2) == 0;
   localparam logic [63:0] HALF_D = 64'(K) << 19;
   localparam int TH = cts_pkg::T_W - cts_pkg::T_LO;

   logic                              incl;
   logic signed [cts_pkg::SUM_W-1:0]  tval;
   logic signed [cts_pkg::SUM_W-1:0]  sum_in;
   logic [cts_pkg::T_LO+cts_pkg::X2_W-1:0] plo_in, plo_ff;
   logic [TH+cts_pkg::X2_W-1:0]       phi_in, phi_ff;
   logic [63:0]                       v;
   logic [cts_pkg::NUM_W-1:0]         n_in, n_ff, q;
   logic [cts_pkg::X2_W-1:0]          x2_a_ff, x2_b_ff, x2_c_ff, x2_d_ff;
   logic signed [cts_pkg::SUM_W-1:0]  sum_a_ff, sum_b_ff, sum_c_ff, sum_d_ff;

   // stage A folds the previous term into the sum when term_limit reaches its power, and starts t * x2
   always_comb begin
      incl   = {1'b0, term_limit} >= cts_pkg::POW_W'(P_PREV);
      tval   = $signed(cts_pkg::SUM_W'(bus_in.t));
      sum_in = bus_in.sum;
      if (incl) begin
         sum_in = ADD ? bus_in.sum + tval : bus_in.sum - tval;
      end
      plo_in = {{cts_pkg::X2_W{1'b0}}, bus_in.t[cts_pkg::T_LO-1:0]}
             * {{cts_pkg::T_LO{1'b0}}, bus_in.x2};
      phi_in = {{cts_pkg::X2_W{1'b0}}, bus_in.t[cts_pkg::T_W-1:cts_pkg::T_LO]}
             * {{TH{1'b0}}, bus_in.x2};
      v      = 64'(plo_ff) + 64'({phi_ff, 22'd0}) + HALF_D;
      n_in   = v[63:20];
   end

   cts_cdiv #(
      .NW  (cts_pkg::NUM_W),
      .DIV (K)
   ) u_div (
      .clock (clock),
      .en    (en[3:2]),
      .n_in  (n_ff),
      .q_out (q)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         x2_a_ff  <= bus_in.x2;
         sum_a_ff <= sum_in;
      end
      if (en[1]) begin
         n_ff     <= n_in;
         x2_b_ff  <= x2_a_ff;
         sum_b_ff <= sum_a_ff;
      end
      if (en[2]) begin
         x2_c_ff  <= x2_b_ff;
         sum_c_ff <= sum_b_ff;
      end
      if (en[3]) begin
         x2_d_ff  <= x2_c_ff;
         sum_d_ff <= sum_c_ff;
      end
   end

   always_comb begin
      bus_out.x2  = x2_d_ff;
      bus_out.t   = q[cts_pkg::T_W-1:0];
      bus_out.sum = sum_d_ff;
   end

endmodule

/* sv/cts_out.sv */
module cts_out #(
   parameter int LAST_POWER = 16
) (
   input  logic                               clock,
   input  logic [1:0]                         en,
   input  logic [cts_pkg::LIMIT_W-1:0]        term_limit,
   input  cts_pkg::term_bus_type              bus_in,
   output logic signed [cts_pkg::OUT_W-1:0]   cos_value,
   output logic                               saturated
);

   localparam bit ADD = ((LAST_POWER / 2) % 2) == 0;
   localparam int Q_W = cts_pkg::SUM_W - 4;

   logic                              incl;
   logic signed [cts_pkg::SUM_W-1:0]  tval, sum_in, sum_ff, rnd;
   logic signed [Q_W-1:0]             q;
   logic signed [cts_pkg::OUT_W-1:0]  cos_in, cos_ff;
   logic                              sat_in, sat_ff;

   always_comb begin
      incl   = {1'b0, term_limit} >= cts_pkg::POW_W'(LAST_POWER);
      tval   = $signed(cts_pkg::SUM_W'(bus_in.t));
      sum_in = bus_in.sum;
      if (incl) begin
         sum_in = ADD ? bus_in.sum + tval : bus_in.sum - tval;
      end
      // Q.20 to Q8.16, round half up; below the bias floor the offset word
      // wraps and the result clips high
      rnd    = sum_ff + cts_pkg::ROUND_Q16;
      q      = Q_W'(rnd >>> 4);
      cos_in = q[cts_pkg::OUT_W-1:0];
      sat_in = 1'b0;
      if (sum_ff < cts_pkg::WRAP_FLOOR) begin
         cos_in = cts_pkg::OUT_MAX;
         sat_in = 1'b1;
      end else if (q > Q_W'(cts_pkg::OUT_MAX)) begin
         cos_in = cts_pkg::OUT_MAX;
         sat_in = 1'b1;
      end else if (q < Q_W'(cts_pkg::OUT_MIN)) begin
         cos_in = cts_pkg::OUT_MIN;
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sum_ff <= sum_in;
      end
      if (en[1]) begin
         cos_ff <= cos_in;
         sat_ff <= sat_in;
      end
   end

   assign cos_value = cos_ff;
   assign saturated = sat_ff;

endmodule

/* sv/cosine_taylor_series.sv */
// Throughput: one angle per cycle while the output is not stalled; each series term is its own
// 4-stage slice (t * x2 product, rounding, constant-reciprocal divide in two stages).
// A stalled output holds only the unbroken run of full stages directly behind it; bubbles close up.
// Reset clears all stage valids and sets term_limit to 5.
module cosine_taylor_series #(
   parameter int MAX_POWER = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // [16:0] angle_deg
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cts_pkg::OUT_W-1:0]         rsp_tdata,   // [23:0] cos_value
   output logic                              rsp_tuser,   // [0] saturated
   input  logic                              csr_wr_en,
   input  logic [cts_pkg::LIMIT_W-1:0]       csr_wr_data
);

   localparam int NT     = MAX_POWER / 2;
   localparam int FRONT  = 5;
   localparam int TERM   = 4;
   localparam int BACK   = 2;
   localparam int STAGES = FRONT + TERM * NT + BACK;

   logic [cts_pkg::LIMIT_W-1:0]       limit_in, limit_ff;
   logic [STAGES-1:0]                 vld_in, vld_ff, en;
   logic                              hold;
   logic [cts_pkg::X2_W-1:0]          x2;
   cts_pkg::term_bus_type             bus [NT+1];
   logic signed [cts_pkg::OUT_W-1:0]  cos_value;
   logic                              saturated;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= cts_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // a stage moves unless it and every stage after it are full and the output stalls
   assign hold = vld_ff[STAGES-1] & ~rsp_tready;

   for (genvar k = 0; k < STAGES; k++) begin : g_en
      assign en[k] = ~(hold & (&vld_ff[STAGES-1:k]));
   end

   assign vld_in = (en & {vld_ff[STAGES-2:0], req_tvalid}) | (~en & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   cts_front u_front (
      .clock     (clock),
      .en        (en[FRONT-1:0]),
      .angle_deg ($signed(req_tdata[cts_pkg::ANGLE_W-1:0])),
      .x2        (x2)
   );

   always_comb begin
      bus[0].x2  = x2;
      bus[0].t   = cts_pkg::TERM_ONE;
      bus[0].sum = '0;
   end

   for (genvar g = 0; g < NT; g++) begin : g_term
      cts_term #(
         .POWER (2 * (g + 1))
      ) u_term (
         .clock      (clock),
         .en         (en[FRONT+TERM*g +: TERM]),
         .term_limit (limit_ff),
         .bus_in     (bus[g]),
         .bus_out    (bus[g+1])
      );
   end

   cts_out #(
      .LAST_POWER (2 * NT)
   ) u_out (
      .clock      (clock),
      .en         (en[STAGES-BACK +: BACK]),
      .term_limit (limit_ff),
      .bus_in     (bus[NT]),
      .cos_value  (cos_value),
      .saturated  (saturated)
   );

   assign req_tready = en[0] & ~reset;
   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = cos_value;
   assign rsp_tuser  = saturated;

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata == cts_pkg::OUT_MAX || rsp_tdata == cts_pkg::OUT_MIN))
      else $error("saturation flag without clipped value");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready && (&vld_ff))
      else $error("input stalled with room in the pipeline");

   a_entry_from_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[0]) |-> $past(req_tvalid && req_tready))
      else $error("first stage filled without an input transfer");

   a_hold_drains_nothing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result lost");

endmodule
